[rtl/gtg_pkg.sv]
package gtg_pkg;

  localparam int FRAC_BITS_DEF   = 8;
  localparam int CORDIC_ITER_DEF = 16;

  // arctangent table depth and its index width
  localparam int TABLE_LEN = 24;
  localparam int IDX_W     = 5;

  // CORDIC datapath widths: vector x/y and angle (1/65536 degree)
  localparam int VW = 40;
  localparam int ZW = 32;

  localparam logic signed [ZW-1:0] FINE_90  = 32'sd5898240;
  localparam logic signed [ZW-1:0] FINE_180 = 32'sd11796480;
  localparam logic signed [ZW-1:0] FINE_360 = 32'sd23592960;
  localparam logic signed [VW-1:0] GAIN_Q30 = 40'sd652032874;
  localparam logic signed [33:0]   GAIN_Q20 = 34'sd636751;

  // heading in 1/128 degree
  localparam logic signed [17:0] HEAD_180 = 18'sd23040;
  localparam logic signed [17:0] HEAD_360 = 18'sd46080;
  localparam logic signed [16:0] ERR_FULL = 17'sd2560;
  localparam logic signed [16:0] ERR_HALF = 17'sd1024;

  // remainder unit: divisor by 360 and its reciprocal, ceil(2^24 / 360)
  localparam logic [8:0]  DIV_HEAD  = 9'd360;
  localparam logic [16:0] RECIP_360 = 17'd46604;
  localparam int          RECIP_SH  = 24;

  typedef enum logic {DIV_360, DIV_80} rem_div_t;

  typedef enum logic [2:0] {
    REG_TARGET_X = 3'd0,
    REG_TARGET_Y = 3'd1,
    REG_START_X  = 3'd2,
    REG_START_Y  = 3'd3,
    REG_TURN     = 3'd4,
    REG_TOL      = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic load;
    logic vec_mode;
  } cordic_cmd_t;

  function automatic logic signed [ZW-1:0] atan_lookup(input logic [IDX_W-1:0] i);
    logic signed [ZW-1:0] v;
    case (i)
      5'd0:    v = 32'sd2949120;
      5'd1:    v = 32'sd1740967;
      5'd2:    v = 32'sd919879;
      5'd3:    v = 32'sd466945;
      5'd4:    v = 32'sd234379;
      5'd5:    v = 32'sd117304;
      5'd6:    v = 32'sd58666;
      5'd7:    v = 32'sd29335;
      5'd8:    v = 32'sd14668;
      5'd9:    v = 32'sd7334;
      5'd10:   v = 32'sd3667;
      5'd11:   v = 32'sd1833;
      5'd12:   v = 32'sd917;
      5'd13:   v = 32'sd458;
      5'd14:   v = 32'sd229;
      5'd15:   v = 32'sd115;
      5'd16:   v = 32'sd57;
      5'd17:   v = 32'sd29;
      5'd18:   v = 32'sd14;
      5'd19:   v = 32'sd7;
      5'd20:   v = 32'sd4;
      5'd21:   v = 32'sd2;
      5'd22:   v = 32'sd1;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

endpackage

[rtl/gtg_mul.sv]
module gtg_mul (
  input  logic               clk,
  input  logic signed [16:0] a,
  input  logic signed [33:0] b,
  output logic signed [50:0] p
);

  always_ff @(posedge clk) begin
    p <= 51'(a) * 51'(b);
  end

endmodule

[rtl/gtg_rem.sv]
module gtg_rem (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  gtg_pkg::rem_div_t  sel,
  input  logic [31:0]        value,
  output logic [31:0]        rem,
  output logic               busy
);
  import gtg_pkg::*;

  rem_div_t    sel_q;
  logic [15:0] val_q;
  logic [6:0]  quo;
  logic [6:0]  nib_sum, nib_q;
  logic [3:0]  low_q;
  logic [31:0] prod;
  logic [4:0]  fold;
  logic [2:0]  r5;
  logic [15:0] quo_mul;

  always_comb begin
    // by 360: reciprocal multiply, exact for values up to 32768
    prod    = 32'(value[15:0]) * 32'(RECIP_360);
    // by 80 = 16 * 5: 16 is 1 mod 5, so the nibbles above bit 3 sum to the same residue
    nib_sum = 7'(value[7:4]) + 7'(value[11:8]) + 7'(value[15:12]) + 7'(value[19:16])
            + 7'(value[23:20]) + 7'(value[27:24]) + 7'(value[31:28]);
    fold    = 5'(nib_q[6:4]) + 5'(nib_q[3:0]);
    if (fold >= 5'd20) begin
      r5 = 3'(fold - 5'd20);
    end else if (fold >= 5'd15) begin
      r5 = 3'(fold - 5'd15);
    end else if (fold >= 5'd10) begin
      r5 = 3'(fold - 5'd10);
    end else if (fold >= 5'd5) begin
      r5 = 3'(fold - 5'd5);
    end else begin
      r5 = fold[2:0];
    end
    quo_mul = 16'(quo) * 16'(DIV_HEAD);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else begin
      busy <= load;
    end
  end

  // partial terms are registered on load, then the remainder while busy
  always_ff @(posedge clk) begin
    if (load) begin
      sel_q <= sel;
      val_q <= value[15:0];
      quo   <= prod[RECIP_SH +: 7];
      nib_q <= nib_sum;
      low_q <= value[3:0];
    end
    if (busy) begin
      rem <= (sel_q == DIV_80) ? 32'({r5, low_q}) : 32'(val_q - quo_mul);
    end
  end

endmodule

[rtl/gtg_cordic.sv]
module gtg_cordic #(
  parameter int ITERATIONS = gtg_pkg::CORDIC_ITER_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  gtg_pkg::cordic_cmd_t             cmd,
  input  logic signed [gtg_pkg::VW-1:0]    x_in,
  input  logic signed [gtg_pkg::VW-1:0]    y_in,
  input  logic signed [gtg_pkg::ZW-1:0]    z_in,
  output logic signed [gtg_pkg::VW-1:0]    x,
  output logic signed [gtg_pkg::VW-1:0]    y,
  output logic signed [gtg_pkg::ZW-1:0]    z,
  output logic                             busy
);
  import gtg_pkg::*;

  logic [IDX_W-1:0]     idx;
  logic                 vec;
  logic                 plus;
  logic signed [VW-1:0] xs, ys;
  logic signed [ZW-1:0] a;

  always_comb begin
    xs   = x >>> idx;
    ys   = y >>> idx;
    a    = atan_lookup(idx);
    // rotation drives z to zero, vectoring drives y to zero
    plus = vec ? !(y > 0) : !z[ZW-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (cmd.load) begin
      busy <= 1'b1;
    end else if (busy && idx == IDX_W'(ITERATIONS - 1)) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x   <= x_in;
      y   <= y_in;
      z   <= z_in;
      vec <= cmd.vec_mode;
      idx <= '0;
    end else if (busy) begin
      if (plus) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - a;
      end else begin
        x <= x + ys;
        y <= y - xs;
        z <= z + a;
      end
      idx <= idx + 1'b1;
    end
  end

endmodule

[rtl/go_to_goal_drive_controller.sv]
// Channel  Dir  Beat carries
// s_axis   in   tdata: delta_angle, delta_distance
// m_axis   out  tdata: right/left wheel speed, distance_to_goal, arrived
// cfg      in   cfg_index, cfg_data: one register write
//
// A taken beat goes through the remainder by 360, then the shared CORDIC unit
// runs rotation and vectoring, then the gain multiply, and reaches the output
// register. s_axis_tready and cfg_ready are high only when idle, so a beat is
// not taken until the previous one has been processed and left S_FIN.
// A result waits in the output register; the next beat may be taken meanwhile,
// and its result is held in S_FIN until the previous one has gone.
// rst is synchronous and restores registers and position at once.
module go_to_goal_drive_controller #(
  parameter int FRAC_BITS         = gtg_pkg::FRAC_BITS_DEF,
  parameter int CORDIC_ITERATIONS = gtg_pkg::CORDIC_ITER_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] delta_angle, [31:16] delta_distance
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [9:0] right_wheel_speed, [19:10] left_wheel_speed,
                                      // [36:20] distance_to_goal, [37] arrived
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import gtg_pkg::*;

  localparam int SH = 30 - FRAC_BITS;

  typedef enum logic [14:0] {
    S_IDLE  = 15'b000000000000001,
    S_HMOD  = 15'b000000000000010,
    S_HEAD  = 15'b000000000000100,
    S_ROT   = 15'b000000000001000,
    S_MULC  = 15'b000000000010000,
    S_MULS  = 15'b000000000100000,
    S_POSY  = 15'b000000001000000,
    S_VLOAD = 15'b000000010000000,
    S_VEC   = 15'b000000100000000,
    S_M0    = 15'b000001000000000,
    S_M1    = 15'b000010000000000,
    S_M2    = 15'b000100000000000,
    S_M3    = 15'b001000000000000,
    S_MAG   = 15'b010000000000000,
    S_FIN   = 15'b100000000000000
  } state_t;

  state_t state, state_next;

  logic [15:0] target_x, target_y;
  logic [8:0]  turn_speed;
  logic [9:0]  stop_tol;
  logic [31:0] pos_x, pos_y, travel;
  logic signed [15:0] heading, desired, bearing;
  logic        ang_neg, sc_neg, zero_vec;
  logic signed [15:0] d_dist;
  logic signed [63:0] acc;
  logic [39:0] mag;

  // shared units
  cordic_cmd_t          ccmd;
  logic signed [VW-1:0] cx_in, cy_in, cx, cy;
  logic signed [ZW-1:0] cz_in, cz;
  logic                 c_busy;
  logic                 r_load, r_busy;
  rem_div_t             r_sel;
  logic [31:0]          r_val, r_rem;
  logic signed [16:0]   ma;
  logic signed [33:0]   mb;
  logic signed [50:0]   mp;

  gtg_cordic #(.ITERATIONS(CORDIC_ITERATIONS)) u_cordic (
    .clk(clk), .rst(rst), .cmd(ccmd), .x_in(cx_in), .y_in(cy_in), .z_in(cz_in),
    .x(cx), .y(cy), .z(cz), .busy(c_busy)
  );

  gtg_rem u_rem (
    .clk(clk), .rst(rst), .load(r_load), .sel(r_sel), .value(r_val),
    .rem(r_rem), .busy(r_busy)
  );

  gtg_mul u_mul (.clk(clk), .a(ma), .b(mb), .p(mp));

  // datapath helpers
  logic               in_acc, out_ok;
  logic signed [15:0] in_ang;
  logic [15:0]        ang_abs;
  logic signed [9:0]  rmod;
  logic signed [17:0] hsum, hwrap;
  logic signed [ZW-1:0] ang;
  logic signed [50:0] prnd;
  logic signed [33:0] dx, dy;
  logic [31:0]        trav_n, trav_mag;
  logic [47:0]        xe;
  logic signed [ZW-1:0] zw, zr;
  logic signed [15:0] des_new;
  logic signed [16:0] err;
  logic [39:0]        tol_q, mm_full;
  logic [16:0]        mm;
  logic               gt;
  logic signed [9:0]  rs, ls, ts, th;

  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == S_IDLE);
  assign cfg_ready     = (state == S_IDLE);
  assign out_ok        = !m_axis_tvalid || m_axis_tready;

  always_comb begin
    in_ang  = $signed(s_axis_tdata[15:0]);
    ang_abs = in_ang[15] ? 16'(-in_ang) : in_ang;
    rmod    = ang_neg ? -$signed({1'b0, r_rem[8:0]}) : $signed({1'b0, r_rem[8:0]});
    hsum    = $signed({{2{heading[15]}}, heading}) + ($signed({{8{rmod[9]}}, rmod}) <<< 7);
    if (hsum >= HEAD_180) begin
      hwrap = hsum - HEAD_360;
    end else if (hsum < -HEAD_180) begin
      hwrap = hsum + HEAD_360;
    end else begin
      hwrap = hsum;
    end
    ang = $signed({{14{hwrap[17]}}, hwrap}) <<< 9;

    prnd = (mp + (51'sd1 <<< (SH - 1))) >>> SH;

    dx = ($signed({{18{target_x[15]}}, target_x}) <<< FRAC_BITS)
       - $signed({{2{pos_x[31]}}, pos_x});
    dy = ($signed({{18{target_y[15]}}, target_y}) <<< FRAC_BITS)
       - $signed({{2{pos_y[31]}}, pos_y});

    trav_n   = travel + 32'($signed(d_dist));
    trav_mag = trav_n[31] ? -trav_n : trav_n;

    xe = {8'd0, cx};

    if (cz > FINE_180) begin
      zw = cz - FINE_360;
    end else if (cz <= -FINE_180) begin
      zw = cz + FINE_360;
    end else begin
      zw = cz;
    end
    zr = (zw + 32'sd256) >>> 9;

    // cordic load
    ccmd  = '0;
    cx_in = '0;
    cy_in = '0;
    cz_in = '0;
    if (state == S_HEAD) begin
      ccmd.load = 1'b1;
      cx_in     = GAIN_Q30;
      if (ang > FINE_90) begin
        cz_in = ang - FINE_180;
      end else if (ang < -FINE_90) begin
        cz_in = ang + FINE_180;
      end else begin
        cz_in = ang;
      end
    end else if (state == S_VLOAD) begin
      ccmd.load     = 1'b1;
      ccmd.vec_mode = 1'b1;
      if (dx < 0) begin
        cx_in = -VW'(dx);
        cy_in = -VW'(dy);
        cz_in = (dy >= 0) ? FINE_180 : -FINE_180;
      end else begin
        cx_in = VW'(dx);
        cy_in = VW'(dy);
      end
    end

    // remainder unit load
    r_load = 1'b0;
    r_sel  = DIV_360;
    r_val  = 32'(ang_abs);
    if (in_acc) begin
      r_load = 1'b1;
    end else if (state == S_VLOAD) begin
      r_load = 1'b1;
      r_sel  = DIV_80;
      r_val  = trav_mag;
    end

    // multiplier operands
    ma = $signed({d_dist[15], d_dist});
    mb = '0;
    case (state)
      S_MULC:  mb = sc_neg ? -34'(cx) : 34'(cx);
      S_MULS:  mb = sc_neg ? -34'(cy) : 34'(cy);
      S_M0: begin
        ma = $signed({1'b0, xe[15:0]});
        mb = GAIN_Q20;
      end
      S_M1: begin
        ma = $signed({1'b0, xe[31:16]});
        mb = GAIN_Q20;
      end
      S_M2: begin
        ma = $signed({1'b0, xe[47:32]});
        mb = GAIN_Q20;
      end
      default: mb = '0;
    endcase

    // decision
    des_new = (r_rem < 32'd20) ? bearing : desired;
    err     = $signed({des_new[15], des_new}) - $signed({heading[15], heading});
    tol_q   = 40'(stop_tol) << FRAC_BITS;
    gt      = mag > tol_q;
    ts      = $signed({1'b0, turn_speed});
    th      = $signed({2'b00, turn_speed[8:1]});
    rs      = '0;
    ls      = '0;
    if (gt && (err > ERR_FULL || err < -ERR_FULL)) begin
      rs = err[16] ? -ts : ts;
      ls = -rs;
    end else if (gt && (err > ERR_HALF || err < -ERR_HALF)) begin
      rs = err[16] ? -th : th;
      ls = -rs;
    end else if (gt) begin
      if (mag < (40'd100 << FRAC_BITS)) begin
        rs = 10'sd20;
      end else if (mag < (40'd150 << FRAC_BITS)) begin
        rs = 10'sd60;
      end else if (mag < (40'd200 << FRAC_BITS)) begin
        rs = 10'sd100;
      end else begin
        rs = 10'sd150;
      end
      ls = rs;
    end
    mm_full = (mag + (40'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    mm      = (mm_full > 40'd131071) ? 17'h1FFFF : mm_full[16:0];
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (in_acc) state_next = S_HMOD;
      S_HMOD:  if (!r_busy) state_next = S_HEAD;
      S_HEAD:  state_next = S_ROT;
      S_ROT:   if (!c_busy) state_next = S_MULC;
      S_MULC:  state_next = S_MULS;
      S_MULS:  state_next = S_POSY;
      S_POSY:  state_next = S_VLOAD;
      S_VLOAD: state_next = S_VEC;
      S_VEC:   if (!c_busy) state_next = S_M0;
      S_M0:    state_next = S_M1;
      S_M1:    state_next = S_M2;
      S_M2:    state_next = S_M3;
      S_M3:    state_next = S_MAG;
      S_MAG:   state_next = S_FIN;
      S_FIN:   if (!r_busy && out_ok) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      m_axis_tvalid <= 1'b0;
      target_x      <= 16'd2100;
      target_y      <= 16'd2500;
      turn_speed    <= 9'd100;
      stop_tol      <= 10'd10;
      pos_x         <= 32'($signed(16'sd2100)) <<< FRAC_BITS;
      pos_y         <= 32'($signed(16'sd300)) <<< FRAC_BITS;
      heading       <= '0;
      desired       <= '0;
      travel        <= '0;
    end else begin
      state <= state_next;
      if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_TARGET_X: target_x   <= cfg_data;
          REG_TARGET_Y: target_y   <= cfg_data;
          REG_START_X:  pos_x      <= 32'($signed(cfg_data)) <<< FRAC_BITS;
          REG_START_Y:  pos_y      <= 32'($signed(cfg_data)) <<< FRAC_BITS;
          REG_TURN:     turn_speed <= cfg_data[8:0];
          REG_TOL:      stop_tol   <= cfg_data[9:0];
          default:      ;
        endcase
      end
      case (state)
        S_HEAD: heading <= hwrap[15:0];
        S_MULS: pos_x   <= pos_x + prnd[31:0];
        S_POSY: pos_y   <= pos_y + prnd[31:0];
        S_VLOAD: travel <= trav_n;
        S_FIN: begin
          if (!r_busy && out_ok) begin
            desired <= des_new;
            if (r_rem < 32'd20) begin
              travel <= '0;
            end
            m_axis_tvalid <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      ang_neg <= in_ang[15];
      d_dist  <= $signed(s_axis_tdata[31:16]);
    end
    if (state == S_HEAD) begin
      sc_neg <= (ang > FINE_90) || (ang < -FINE_90);
    end
    if (state == S_VLOAD) begin
      zero_vec <= (dx == 34'sd0) && (dy == 34'sd0);
    end
    case (state)
      S_M1:    acc <= 64'(mp);
      S_M2:    acc <= acc + (64'(mp) <<< 16);
      S_M3:    acc <= acc + (64'(mp) <<< 32);
      default: ;
    endcase
    if (state == S_MAG) begin
      mag     <= 40'((acc + 64'sd524288) >>> 20);
      bearing <= zero_vec ? 16'sd0 : zr[15:0];
    end
    if (state == S_FIN && !r_busy && out_ok) begin
      m_axis_tdata <= {2'b00, (mag < tol_q), mm, ls, rs};
    end
  end

endmodule
